FILE: rtl/imu_motion_segment_integrator_core_macros.svh
// assertion macros for the imu motion segment integrator
`ifndef IMU_MOTION_SEGMENT_INTEGRATOR_CORE_MACROS_SVH
`define IMU_MOTION_SEGMENT_INTEGRATOR_CORE_MACROS_SVH
`ifndef SYNTH
`define IMSI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("imsi assertion failed");
`define IMSI_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("imsi assertion failed");
`else
`define IMSI_ASSERT_IMP(label, ante, cons)
`define IMSI_ASSERT_NXT(label, ante, cons)
`endif
`endif

FILE: rtl/imsi_pkg.sv
// shared types and constants of the imu motion segment integrator
`timescale 1ns / 1ps
package imsi_pkg;
  localparam int NCh          = 6;
  localparam int NAccel       = 3;
  localparam int ChW          = 3;
  localparam int ChZ          = 2;
  localparam int ChPitch      = 3;
  localparam int ChRoll       = 4;
  localparam int MulW         = 26;
  localparam int ProdW        = 2 * MulW;
  localparam int WindowLenDef = 16;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACC_THR       = 3'd0,
    CFG_PITCH_THR     = 3'd1,
    CFG_ROLL_THR      = 3'd2,
    CFG_YAW_THR       = 3'd3,
    CFG_GRAVITY_DT    = 3'd4,
    CFG_SAMPLE_PERIOD = 3'd5,
    CFG_Z_OFFSET      = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [30:0]        thr_acc;
    logic [30:0]        thr_pitch;
    logic [30:0]        thr_roll;
    logic [30:0]        thr_yaw;
    logic [23:0]        gravity_dt;
    logic [23:0]        sample_period;
    logic signed [15:0] z_offset;
  } cfg_t;

  typedef struct packed {
    logic [NCh-1:0][15:0] ch;
    logic [31:0]          ts;
  } sample_t;

  typedef struct packed {
    logic    valid;
    sample_t data;
  } queue_head_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_SQO, ST_SQN, ST_ACC, ST_VMUL, ST_VCMP, ST_DEC,
    ST_IRD, ST_IM1, ST_IV, ST_IM2, ST_IM3, ST_ID, ST_EMIT
  } back_st_e;
endpackage

FILE: rtl/imsi_front.sv
// front end: sample intake, gravity offset on z and a two-entry queue
`timescale 1ns / 1ps
module imsi_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  imsi_pkg::cfg_t            cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [15:0]        accel_x_i,
  input  logic signed [15:0]        accel_y_i,
  input  logic signed [15:0]        accel_z_i,
  input  logic signed [15:0]        pitch_rate_i,
  input  logic signed [15:0]        roll_rate_i,
  input  logic signed [15:0]        yaw_rate_i,
  input  logic [31:0]               timestamp_i,
  input  logic                      pop_i,
  output imsi_pkg::queue_head_t     head_o
);
  logic [1:0]          cnt_q, cnt_d;
  logic                wr_q, rd_q;
  imsi_pkg::sample_t   buf_q [2];
  imsi_pkg::sample_t   smp;
  logic signed [16:0]  zsum;
  logic                push, pop;

  always_comb begin
    zsum = 17'(accel_z_i) + 17'(cfg_i.z_offset);
    smp.ch[0] = accel_x_i;
    smp.ch[1] = accel_y_i;
    if (zsum[16] != zsum[15]) begin
      smp.ch[imsi_pkg::ChZ] = zsum[16] ? 16'h8000 : 16'h7fff;
    end else begin
      smp.ch[imsi_pkg::ChZ] = zsum[15:0];
    end
    smp.ch[imsi_pkg::ChPitch] = pitch_rate_i;
    smp.ch[imsi_pkg::ChRoll]  = roll_rate_i;
    smp.ch[5] = yaw_rate_i;
    smp.ts = timestamp_i;
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign push         = in_valid_i & in_ready_o;
  assign pop          = pop_i & head_o.valid;
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.data  = buf_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= smp;
  end
endmodule

FILE: rtl/imsi_mul.sv
// shared signed multiplier with registered product
`timescale 1ns / 1ps
module imsi_mul (
  input  logic                                clk_i,
  input  logic signed [imsi_pkg::MulW-1:0]    a_i,
  input  logic signed [imsi_pkg::MulW-1:0]    b_i,
  output logic signed [imsi_pkg::ProdW-1:0]   p_o
);
  logic signed [imsi_pkg::ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;
endmodule

FILE: rtl/imsi_back.sv
// back end: window memories, running sums, variance test and segment integration
`timescale 1ns / 1ps
`include "imu_motion_segment_integrator_core_macros.svh"
module imsi_back #(
  parameter int WINDOW_LEN = imsi_pkg::WindowLenDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  imsi_pkg::cfg_t         cfg_i,
  input  imsi_pkg::queue_head_t  head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [47:0]     move_x_o,
  output logic signed [47:0]     move_y_o,
  output logic signed [47:0]     move_z_o,
  output logic signed [47:0]     turn_pitch_o,
  output logic signed [47:0]     turn_roll_o,
  output logic signed [47:0]     turn_yaw_o,
  output logic [31:0]            begin_time_o,
  output logic [31:0]            finish_time_o,
  output logic [31:0]            begin_index_o,
  output logic [31:0]            finish_index_o
);
  localparam int NCh   = imsi_pkg::NCh;
  localparam int ChW   = imsi_pkg::ChW;
  localparam int MulW  = imsi_pkg::MulW;
  localparam int ProdW = imsi_pkg::ProdW;
  localparam int LW    = $clog2(WINDOW_LEN);
  localparam int FW    = $clog2(WINDOW_LEN + 1);
  localparam int AW    = $clog2(WINDOW_LEN * NCh);
  localparam int SumW  = 17 + LW;
  localparam int SqW   = 31 + LW;
  localparam int NumW  = 33 + 2 * LW;

  imsi_pkg::back_st_e st_q, st_d;
  logic [ChW-1:0]      c_q, c_d;
  imsi_pkg::sample_t   smp_q;
  logic [LW-1:0]       wp_q;
  logic [FW-1:0]       fill_q;
  logic [31:0]         cnt_q;
  logic                in_seg_q, moving_q;
  logic [31:0]         start_idx_q, start_time_q;
  logic signed [SumW-1:0] sum_q [NCh];
  logic [SqW-1:0]      sq_q [NCh];
  logic signed [39:0]  vel_q [imsi_pkg::NAccel];
  logic signed [47:0]  dist_q [NCh];
  logic signed [40:0]  sumv_q;
  logic signed [49:0]  part_q;
  logic [15:0]         rdata_q;
  logic [31:0]         time_q;
  logic [15:0]         smem [WINDOW_LEN * NCh];
  logic [31:0]         tmem [WINDOW_LEN];
  logic signed [47:0]  out_dist_q [NCh];
  logic [31:0]         out_bt_q, out_ft_q, out_bi_q, out_fi_q;
  logic                out_valid_q;

  logic                full, will_full, last_ch, is_acc, out_free;
  logic [AW-1:0]       addr;
  logic                smem_we, smem_re;
  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0] prod;
  logic signed [15:0]  old_s, new_s;
  logic [NumW-1:0]     wq, thrw;
  logic signed [NumW-1:0] num;
  logic [30:0]         thr;
  logic                exceed;
  logic signed [39:0]  vnew;
  logic signed [49:0]  part_s;
  logic signed [48:0]  step;
  logic signed [47:0]  dnew;
  logic [31:0]         idx;

  function automatic logic signed [39:0] sat40(input logic signed [40:0] x);
    if (x[40] != x[39]) return x[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
    return x[39:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [48:0] x);
    if (x[48] != x[47]) return x[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    return x[47:0];
  endfunction

  imsi_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign full      = (fill_q == FW'(WINDOW_LEN));
  assign will_full = full || (fill_q == FW'(WINDOW_LEN - 1));
  assign last_ch   = (c_q == ChW'(NCh - 1));
  assign is_acc    = (c_q < ChW'(imsi_pkg::NAccel));
  assign out_free  = !out_valid_q || out_ready_i;
  assign addr      = AW'(wp_q) * AW'(NCh) + AW'(c_q);
  assign old_s     = full ? signed'(rdata_q) : 16'sd0;
  assign new_s     = signed'(smp_q.ch[c_q]);
  assign idx       = cnt_q - 32'(WINDOW_LEN);

  // variance test: W*Q - S*S against T*W*W
  always_comb begin
    priority if (is_acc) thr = cfg_i.thr_acc;
    else if (c_q == ChW'(imsi_pkg::ChPitch)) thr = cfg_i.thr_pitch;
    else if (c_q == ChW'(imsi_pkg::ChRoll)) thr = cfg_i.thr_roll;
    else thr = cfg_i.thr_yaw;
    wq     = NumW'(sq_q[c_q]) * NumW'(WINDOW_LEN);
    thrw   = NumW'(thr) * NumW'(WINDOW_LEN * WINDOW_LEN);
    num    = signed'(wq) - signed'(NumW'(prod));
    exceed = num > signed'(thrw);
  end

  // integration arithmetic
  always_comb begin
    vnew   = sat40(41'(vel_q[c_q[1:0]]) + 41'(prod >>> 16));
    part_s = part_q + 50'(prod >>> 16);
    step   = is_acc ? 49'(part_s >>> 9) : 49'(prod >>> 16);
    dnew   = sat48(49'(dist_q[c_q]) + step);
  end

  always_comb begin
    st_d = st_q;
    c_d  = c_q;
    unique case (st_q)
      imsi_pkg::ST_IDLE: begin
        if (head_i.valid) begin
          st_d = imsi_pkg::ST_RD;
          c_d  = '0;
        end
      end
      imsi_pkg::ST_RD:  st_d = imsi_pkg::ST_SQO;
      imsi_pkg::ST_SQO: st_d = imsi_pkg::ST_SQN;
      imsi_pkg::ST_SQN: st_d = imsi_pkg::ST_ACC;
      imsi_pkg::ST_ACC: begin
        if (!last_ch) begin
          st_d = imsi_pkg::ST_RD;
          c_d  = c_q + 1'b1;
        end else begin
          st_d = will_full ? imsi_pkg::ST_VMUL : imsi_pkg::ST_IDLE;
          c_d  = '0;
        end
      end
      imsi_pkg::ST_VMUL: st_d = imsi_pkg::ST_VCMP;
      imsi_pkg::ST_VCMP: begin
        if (!last_ch) begin
          st_d = imsi_pkg::ST_VMUL;
          c_d  = c_q + 1'b1;
        end else begin
          st_d = imsi_pkg::ST_DEC;
          c_d  = '0;
        end
      end
      imsi_pkg::ST_DEC: begin
        st_d = (moving_q || in_seg_q) ? imsi_pkg::ST_IRD : imsi_pkg::ST_IDLE;
      end
      imsi_pkg::ST_IRD: st_d = imsi_pkg::ST_IM1;
      imsi_pkg::ST_IM1: st_d = is_acc ? imsi_pkg::ST_IV : imsi_pkg::ST_ID;
      imsi_pkg::ST_IV:  st_d = imsi_pkg::ST_IM2;
      imsi_pkg::ST_IM2: st_d = imsi_pkg::ST_IM3;
      imsi_pkg::ST_IM3: st_d = imsi_pkg::ST_ID;
      imsi_pkg::ST_ID: begin
        if (!last_ch) begin
          st_d = imsi_pkg::ST_IRD;
          c_d  = c_q + 1'b1;
        end else begin
          st_d = moving_q ? imsi_pkg::ST_IDLE : imsi_pkg::ST_EMIT;
          c_d  = '0;
        end
      end
      imsi_pkg::ST_EMIT: if (out_free) st_d = imsi_pkg::ST_IDLE;
      default: st_d = imsi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o   = 1'b0;
    smem_we = 1'b0;
    smem_re = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    unique case (st_q)
      imsi_pkg::ST_IDLE: pop_o = head_i.valid;
      imsi_pkg::ST_RD: begin
        smem_we = 1'b1;
        smem_re = 1'b1;
      end
      imsi_pkg::ST_SQO: begin
        mul_a = MulW'(old_s);
        mul_b = MulW'(old_s);
      end
      imsi_pkg::ST_SQN: begin
        mul_a = MulW'(new_s);
        mul_b = MulW'(new_s);
      end
      imsi_pkg::ST_VMUL: begin
        mul_a = MulW'(sum_q[c_q]);
        mul_b = MulW'(sum_q[c_q]);
      end
      imsi_pkg::ST_IRD: smem_re = 1'b1;
      imsi_pkg::ST_IM1: begin
        mul_a = MulW'(signed'(rdata_q));
        mul_b = is_acc ? {2'b00, cfg_i.gravity_dt} : {2'b00, cfg_i.sample_period};
      end
      imsi_pkg::ST_IM2: begin
        mul_a = MulW'(sumv_q >>> 16);
        mul_b = {2'b00, cfg_i.sample_period};
      end
      imsi_pkg::ST_IM3: begin
        mul_a = {10'd0, sumv_q[15:0]};
        mul_b = {2'b00, cfg_i.sample_period};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // window memories, read data registered
  always_ff @(posedge clk_i) begin
    if (smem_we) smem[addr] <= smp_q.ch[c_q];
    if (smem_re) rdata_q <= smem[addr];
    if (st_q == imsi_pkg::ST_RD && c_q == '0) tmem[wp_q] <= smp_q.ts;
    if (st_q == imsi_pkg::ST_VMUL) time_q <= tmem[wp_q];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) smp_q <= head_i.data;
    if (st_q == imsi_pkg::ST_IV) sumv_q <= 41'(vnew) + 41'(vel_q[c_q[1:0]]);
    if (st_q == imsi_pkg::ST_IM3) part_q <= 50'(prod);
    if (st_q == imsi_pkg::ST_EMIT && out_free) begin
      for (int i = 0; i < NCh; i++) out_dist_q[i] <= dist_q[i];
      out_bt_q <= start_time_q;
      out_ft_q <= time_q;
      out_bi_q <= start_idx_q;
      out_fi_q <= idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= imsi_pkg::ST_IDLE;
      c_q          <= '0;
      wp_q         <= '0;
      fill_q       <= '0;
      cnt_q        <= '0;
      in_seg_q     <= 1'b0;
      moving_q     <= 1'b0;
      start_idx_q  <= '0;
      start_time_q <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < NCh; i++) begin
        sum_q[i]  <= '0;
        sq_q[i]   <= '0;
        dist_q[i] <= '0;
      end
      for (int i = 0; i < imsi_pkg::NAccel; i++) vel_q[i] <= '0;
    end else begin
      st_q <= st_d;
      c_q  <= c_d;
      if (st_q == imsi_pkg::ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        imsi_pkg::ST_SQO: begin
          sum_q[c_q] <= sum_q[c_q] + SumW'(new_s) - SumW'(old_s);
        end
        imsi_pkg::ST_SQN: sq_q[c_q] <= sq_q[c_q] - SqW'(prod);
        imsi_pkg::ST_ACC: begin
          sq_q[c_q] <= sq_q[c_q] + SqW'(prod);
          if (last_ch) begin
            wp_q     <= (wp_q == LW'(WINDOW_LEN - 1)) ? '0 : wp_q + 1'b1;
            cnt_q    <= cnt_q + 32'd1;
            moving_q <= 1'b0;
            if (!full) fill_q <= fill_q + 1'b1;
          end
        end
        imsi_pkg::ST_VCMP: if (exceed) moving_q <= 1'b1;
        imsi_pkg::ST_DEC: begin
          if (moving_q && !in_seg_q) begin
            in_seg_q     <= 1'b1;
            start_idx_q  <= idx;
            start_time_q <= time_q;
            for (int i = 0; i < NCh; i++) dist_q[i] <= '0;
            for (int i = 0; i < imsi_pkg::NAccel; i++) vel_q[i] <= '0;
          end
        end
        imsi_pkg::ST_IV: vel_q[c_q[1:0]] <= vnew;
        imsi_pkg::ST_ID: dist_q[c_q] <= dnew;
        imsi_pkg::ST_EMIT: begin
          if (out_free) in_seg_q <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign move_x_o       = out_dist_q[0];
  assign move_y_o       = out_dist_q[1];
  assign move_z_o       = out_dist_q[imsi_pkg::ChZ];
  assign turn_pitch_o   = out_dist_q[imsi_pkg::ChPitch];
  assign turn_roll_o    = out_dist_q[imsi_pkg::ChRoll];
  assign turn_yaw_o     = out_dist_q[5];
  assign begin_time_o   = out_bt_q;
  assign finish_time_o  = out_ft_q;
  assign begin_index_o  = out_bi_q;
  assign finish_index_o = out_fi_q;

  `IMSI_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= FW'(WINDOW_LEN))
  `IMSI_ASSERT_IMP(a_emit_closes, st_q == imsi_pkg::ST_EMIT, in_seg_q && !moving_q)
  `IMSI_ASSERT_NXT(a_pop_starts, pop_o, st_q == imsi_pkg::ST_RD && c_q == '0)
endmodule

FILE: rtl/imu_motion_segment_integrator_core.sv
// top level of the imu motion segment integrator: config registers, front and back
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid_i / in_ready_o | accel x/y/z, pitch/roll/yaw rate, timestamp
//  out     | out_valid_o / out_ready_i | six displacements, times, indices
//  cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// a sample takes only the window update while the window fills; once full it adds the
// variance test, then integration when moving or in a segment, and an emit step when it closes one
// the back end steps through these one sample at a time on the one shared multiplier
// the front queue holds two samples, so intake continues while a result waits
// reset clears sums, counters and segment state; window memories need no clearing
`timescale 1ns / 1ps
module imu_motion_segment_integrator_core #(
  parameter int WINDOW_LEN = imsi_pkg::WindowLenDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [imsi_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [imsi_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [15:0]              accel_x_i,
  input  logic signed [15:0]              accel_y_i,
  input  logic signed [15:0]              accel_z_i,
  input  logic signed [15:0]              pitch_rate_i,
  input  logic signed [15:0]              roll_rate_i,
  input  logic signed [15:0]              yaw_rate_i,
  input  logic [31:0]                     timestamp_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [47:0]              move_x_o,
  output logic signed [47:0]              move_y_o,
  output logic signed [47:0]              move_z_o,
  output logic signed [47:0]              turn_pitch_o,
  output logic signed [47:0]              turn_roll_o,
  output logic signed [47:0]              turn_yaw_o,
  output logic [31:0]                     begin_time_o,
  output logic [31:0]                     finish_time_o,
  output logic [31:0]                     begin_index_o,
  output logic [31:0]                     finish_index_o
);
  imsi_pkg::cfg_t        cfg_q;
  imsi_pkg::queue_head_t head;
  logic                  pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (imsi_pkg::cfg_reg_e'(cfg_index_i))
        imsi_pkg::CFG_ACC_THR:       cfg_q.thr_acc       <= cfg_data_i[30:0];
        imsi_pkg::CFG_PITCH_THR:     cfg_q.thr_pitch     <= cfg_data_i[30:0];
        imsi_pkg::CFG_ROLL_THR:      cfg_q.thr_roll      <= cfg_data_i[30:0];
        imsi_pkg::CFG_YAW_THR:       cfg_q.thr_yaw       <= cfg_data_i[30:0];
        imsi_pkg::CFG_GRAVITY_DT:    cfg_q.gravity_dt    <= cfg_data_i[23:0];
        imsi_pkg::CFG_SAMPLE_PERIOD: cfg_q.sample_period <= cfg_data_i[23:0];
        imsi_pkg::CFG_Z_OFFSET:      cfg_q.z_offset      <= signed'(cfg_data_i[15:0]);
        default: begin
        end
      endcase
    end
  end

  imsi_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .accel_x_i    (accel_x_i),
    .accel_y_i    (accel_y_i),
    .accel_z_i    (accel_z_i),
    .pitch_rate_i (pitch_rate_i),
    .roll_rate_i  (roll_rate_i),
    .yaw_rate_i   (yaw_rate_i),
    .timestamp_i  (timestamp_i),
    .pop_i        (pop),
    .head_o       (head)
  );

  imsi_back #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .move_x_o       (move_x_o),
    .move_y_o       (move_y_o),
    .move_z_o       (move_z_o),
    .turn_pitch_o   (turn_pitch_o),
    .turn_roll_o    (turn_roll_o),
    .turn_yaw_o     (turn_yaw_o),
    .begin_time_o   (begin_time_o),
    .finish_time_o  (finish_time_o),
    .begin_index_o  (begin_index_o),
    .finish_index_o (finish_index_o)
  );
endmodule

FILE: tb/imu_motion_segment_integrator_core_tb.sv
// self-checking testbench for the imu motion segment integrator core
`timescale 1ns / 1ps
module imu_motion_segment_integrator_core_tb;
  localparam int  Win       = imsi_pkg::WindowLenDef;
  localparam int  CycleCap  = 1_000_000;
  localparam int  DrainWait = 500;
  localparam int  PhaseLen  = 290;
  localparam logic [imsi_pkg::CfgIdxW-1:0] CfgNoReg = 3'd7;
  localparam longint ThrMax = 64'd1073741824;

  typedef struct {
    longint          disp [6];
    longint unsigned bt, ft, bi, fi;
  } segment_t;

  class segment_scoreboard;
    longint thr [4];
    longint gdt, per, zoff;
    int     win_s [Win][6];
    longint win_t [Win];
    longint ch_sum [6];
    longint ch_sq [6];
    int     fill;
    longint count;
    bit     in_seg;
    longint seg_idx, seg_t;
    longint vel [3];
    longint disp_acc [6];
    segment_t pending [$];
    int     errors;
    int     checked;

    function new();
      foreach (thr[i]) thr[i] = 0;
      gdt = 0; per = 0; zoff = 0;
      foreach (ch_sum[i]) begin ch_sum[i] = 0; ch_sq[i] = 0; disp_acc[i] = 0; end
      foreach (vel[i]) vel[i] = 0;
      fill = 0; count = 0; in_seg = 0; seg_idx = 0; seg_t = 0;
      errors = 0; checked = 0;
    endfunction

    function longint sat(longint x, int w);
      longint hi, lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      return (x > hi) ? hi : (x < lo) ? lo : x;
    endfunction

    function void apply_cfg(logic [imsi_pkg::CfgIdxW-1:0] idx, logic [31:0] d);
      case (idx)
        imsi_pkg::CFG_ACC_THR:       thr[0] = d[30:0];
        imsi_pkg::CFG_PITCH_THR:     thr[1] = d[30:0];
        imsi_pkg::CFG_ROLL_THR:      thr[2] = d[30:0];
        imsi_pkg::CFG_YAW_THR:       thr[3] = d[30:0];
        imsi_pkg::CFG_GRAVITY_DT:    gdt = d[23:0];
        imsi_pkg::CFG_SAMPLE_PERIOD: per = d[23:0];
        imsi_pkg::CFG_Z_OFFSET:      zoff = longint'($signed(d[15:0]));
        default: ;
      endcase
    endfunction

    function bit window_moving();
      longint num, t;
      for (int c = 0; c < 6; c++) begin
        num = Win * ch_sq[c] - ch_sum[c] * ch_sum[c];
        t = (c < 3) ? thr[0] : thr[c - 2];
        if (num > t * Win * Win) return 1;
      end
      return 0;
    endfunction

    function void integrate_oldest();
      longint prev, v, sm, hi, lo, part;
      for (int c = 0; c < 3; c++) begin
        prev = vel[c];
        v = sat(prev + ((longint'(win_s[0][c]) * gdt) >>> 16), 40);
        sm = v + prev;
        hi = sm >>> 16;
        lo = sm - hi * 65536;
        part = hi * per + ((lo * per) >>> 16);
        vel[c] = v;
        disp_acc[c] = sat(disp_acc[c] + (part >>> 9), 48);
      end
      for (int c = 3; c < 6; c++)
        disp_acc[c] = sat(disp_acc[c] + ((longint'(win_s[0][c]) * per) >>> 16), 48);
    endfunction

    // one accepted sample transaction
    function void note_sample(int s_in [6], logic [31:0] ts);
      int s [6];
      longint idx;
      segment_t r;
      s = s_in;
      s[2] = int'(sat(longint'(s[2]) + zoff, 16));
      if (fill >= Win) begin
        for (int c = 0; c < 6; c++) begin
          ch_sum[c] -= win_s[0][c];
          ch_sq[c]  -= longint'(win_s[0][c]) * win_s[0][c];
        end
        for (int k = 0; k < Win - 1; k++) begin
          win_s[k] = win_s[k + 1];
          win_t[k] = win_t[k + 1];
        end
        fill = Win - 1;
      end
      for (int c = 0; c < 6; c++) begin
        win_s[fill][c] = s[c];
        ch_sum[c] += s[c];
        ch_sq[c]  += longint'(s[c]) * s[c];
      end
      win_t[fill] = ts;
      fill++;
      count = (count + 1) & 64'hFFFF_FFFF;
      if (fill < Win) return;
      idx = (count - Win) & 64'hFFFF_FFFF;
      if (window_moving()) begin
        if (!in_seg) begin
          in_seg = 1;
          seg_idx = idx;
          seg_t = win_t[0];
          foreach (vel[i]) vel[i] = 0;
          foreach (disp_acc[i]) disp_acc[i] = 0;
        end
        integrate_oldest();
        return;
      end
      if (!in_seg) return;
      integrate_oldest();
      in_seg = 0;
      r.disp = disp_acc;
      r.bt = seg_t; r.ft = win_t[0]; r.bi = seg_idx; r.fi = idx;
      pending.push_back(r);
    endfunction

    function void check_result(segment_t got);
      segment_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected segment result, begin_index %0d", $time, got.bi);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      for (int c = 0; c < 6; c++)
        if (e.disp[c] !== got.disp[c]) begin
          $display("%0t: displacement %0d expected %0d actual %0d",
                   $time, c, e.disp[c], got.disp[c]);
          errors++;
        end
      if (e.bt !== got.bt) begin
        $display("%0t: begin_time expected %0d actual %0d", $time, e.bt, got.bt);
        errors++;
      end
      if (e.ft !== got.ft) begin
        $display("%0t: finish_time expected %0d actual %0d", $time, e.ft, got.ft);
        errors++;
      end
      if (e.bi !== got.bi) begin
        $display("%0t: begin_index expected %0d actual %0d", $time, e.bi, got.bi);
        errors++;
      end
      if (e.fi !== got.fi) begin
        $display("%0t: finish_index expected %0d actual %0d", $time, e.fi, got.fi);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [imsi_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [imsi_pkg::CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] ax = '0, ay = '0, az = '0, pr = '0, rr = '0, yr = '0;
  logic [31:0] ts_q = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [47:0] mx, my, mz, tp, tr, ty;
  logic [31:0] bt, ft, bi, fi;

  imu_motion_segment_integrator_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .accel_x_i     (ax),
    .accel_y_i     (ay),
    .accel_z_i     (az),
    .pitch_rate_i  (pr),
    .roll_rate_i   (rr),
    .yaw_rate_i    (yr),
    .timestamp_i   (ts_q),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .move_x_o      (mx),
    .move_y_o      (my),
    .move_z_o      (mz),
    .turn_pitch_o  (tp),
    .turn_roll_o   (tr),
    .turn_yaw_o    (ty),
    .begin_time_o  (bt),
    .finish_time_o (ft),
    .begin_index_o (bi),
    .finish_index_o(fi)
  );

  segment_scoreboard sb = new();

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  int cycles = 0;
  int stall_mode = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("imu_motion_segment_integrator_core: mismatch");
      $finish;
    end
    if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      2: out_ready <= ((cycles % 11) < 3);
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // a result transaction completes at the next rising edge
  always @(negedge clk_i) begin
    segment_t got;
    if (rst_n && out_valid && out_ready) begin
      got.disp[0] = mx; got.disp[1] = my; got.disp[2] = mz;
      got.disp[3] = tp; got.disp[4] = tr; got.disp[5] = ty;
      got.bt = bt; got.ft = ft; got.bi = bi; got.fi = fi;
      sb.check_result(got);
    end
  end

  int burst_left = 0;
  int items = 0;
  int phases = 0;

  task automatic send_sample(input int s [6], input logic [31:0] t);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    ax <= 16'(s[0]); ay <= 16'(s[1]); az <= 16'(s[2]);
    pr <= 16'(s[3]); rr <= 16'(s[4]); yr <= 16'(s[5]);
    ts_q <= t;
    @(negedge clk_i);
    while (!in_ready) @(negedge clk_i);
    @(posedge clk_i);
    sb.note_sample(s, t);
    items++;
  endtask

  task automatic write_reg(input logic [imsi_pkg::CfgIdxW-1:0] idx, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk_i);
    while (!cfg_ready) @(negedge clk_i);
    @(posedge clk_i);
    sb.apply_cfg(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic set_all(input longint ta, tpit, trol, tyaw, g, p, z);
    write_reg(imsi_pkg::CFG_ACC_THR, 32'(ta));
    write_reg(imsi_pkg::CFG_PITCH_THR, 32'(tpit));
    write_reg(imsi_pkg::CFG_ROLL_THR, 32'(trol));
    write_reg(imsi_pkg::CFG_YAW_THR, 32'(tyaw));
    write_reg(imsi_pkg::CFG_GRAVITY_DT, 32'(g));
    write_reg(imsi_pkg::CFG_SAMPLE_PERIOD, 32'(p));
    write_reg(imsi_pkg::CFG_Z_OFFSET, 32'(z & 64'hFFFF));
    phases++;
  endtask

  function automatic longint pick_thr(int p);
    case (p)
      0: return $urandom_range(50, 5000);
      1: return ThrMax;
      2: return 0;
      default: case ($urandom_range(0, 3))
        0: return $urandom_range(8, 30);
        1: return $urandom_range(30, 20000);
        2: return $urandom_range(1 << 20, 1 << 28);
        default: return ThrMax;
      endcase
    endcase
  endfunction

  function automatic int clip16(int v);
    return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
  endfunction

  initial begin
    int s [6];
    int base [6];
    logic [31:0] t;
    int noise, run, loud_mask, loud_amp, left;
    longint th [4];

    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed: zero thresholds, largest factors, z offset at its top
    set_all(0, 0, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 32767);
    write_reg(CfgNoReg, 32'hFFFF_FFFF);
    t = 32'hFFFF_FFF0;
    for (int k = 0; k < 16; k++) begin
      foreach (s[c]) s[c] = 32767;
      send_sample(s, t);
      t += 1;
    end
    for (int k = 0; k < 6; k++) begin
      foreach (s[c]) s[c] = (k % 2) ? -32768 : 32767;
      send_sample(s, t);
      t += 1;
    end
    foreach (s[c]) s[c] = -32768;
    for (int k = 0; k < 3; k++) begin
      send_sample(s, t);
      t += 1;
    end
    drain();
    set_all(0, 0, 0, 0, 24'hFFFFFF, 24'hFFFFFF, -32768);
    for (int k = 0; k < 20; k++) begin
      foreach (s[c]) s[c] = (k < 4) ? ((k % 2) ? -32768 : 32767) : 0;
      send_sample(s, t);
      t += 7;
    end
    drain();

    for (int p = 0; p < 6; p++) begin
      foreach (th[i]) th[i] = pick_thr(p);
      set_all(th[0], th[1], th[2], th[3],
              (p == 1) ? 0 : (p == 2) ? 24'hFFFFFF : $urandom_range(0, 24'hFFFFFF),
              (p == 1) ? 0 : (p == 2) ? 24'hFFFFFF : $urandom_range(0, 24'hFFFFFF),
              (p == 3) ? -32768 : (p == 4) ? 32767 : $signed(16'($urandom())));
      noise = (th[0] == 0 || th[1] == 0 || th[2] == 0 || th[3] == 0) ? 0 : 2;
      left = PhaseLen;
      while (left > 0) begin
        // still stretch around a random level, then a loud stretch
        foreach (base[c]) base[c] = $signed(16'($urandom()));
        run = $urandom_range(10, 40);
        for (int k = 0; k < run && left > 0; k++, left--) begin
          foreach (s[c]) s[c] = clip16(base[c] + $urandom_range(0, 2 * noise) - noise);
          t += $urandom_range(1, 1000);
          send_sample(s, t);
        end
        loud_mask = ($urandom_range(0, 1)) ? 6'h3F : (1 << $urandom_range(0, 5));
        loud_amp = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 400) : 32768;
        run = $urandom_range(1, 25);
        for (int k = 0; k < run && left > 0; k++, left--) begin
          foreach (s[c])
            s[c] = loud_mask[c] ? clip16(base[c] + $urandom_range(0, 2 * loud_amp)
                                           - loud_amp)
                                : base[c];
          if ($urandom_range(0, 9) == 0) t = $urandom();
          else t += $urandom_range(1, 1000);
          send_sample(s, t);
        end
      end
      drain();
    end

    $display("%0d samples sent over %0d register settings, %0d segment results checked",
             items, phases, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("imu_motion_segment_integrator_core: match");
    else
      $display("imu_motion_segment_integrator_core: mismatch");
    $finish;
  end
endmodule

FILE: sim.f
+incdir+rtl
rtl/imsi_pkg.sv
rtl/imsi_front.sv
rtl/imsi_mul.sv
rtl/imsi_back.sv
rtl/imu_motion_segment_integrator_core.sv
tb/imu_motion_segment_integrator_core_tb.sv
